// File: rtl/l1_nearest_codeword_quantizer_unit_assert.svh
// ----------------------------------------------------------------------------
// L1 nearest-codeword quantizer assertion macros
// Concurrent checks sampled on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef L1_NEAREST_CODEWORD_QUANTIZER_UNIT_ASSERT_SVH
`define L1_NEAREST_CODEWORD_QUANTIZER_UNIT_ASSERT_SVH

// Check a same-cycle implication
`define L1NCQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check an implication in the next cycle
`define L1NCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/l1ncq_pkg.sv
// ----------------------------------------------------------------------------
// l1ncq_pkg
// Shared types and constants of the L1 nearest-codeword quantizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package l1ncq_pkg;

  // Default sizes of the codebook store
  localparam int MAX_CENTERS_DEF = 64;
  localparam int MAX_DIM_DEF     = 256;

  // Fixed field widths
  localparam int NC_W     = 7;   // num_centers register
  localparam int FL_W     = 9;   // feature_length register
  localparam int CFG_W    = 9;   // configuration write data
  localparam int VAL_W    = 16;  // Q8.7 element
  localparam int CI_W     = 6;
  localparam int DI_W     = 8;
  localparam int LABEL_W  = 6;
  localparam int DIST_W   = 24;
  localparam int CNT_W    = 9;
  localparam int IN_DW    = 32;
  localparam int OUT_DW   = 32;

  localparam logic [DIST_W-1:0] DIST_MAX  = '1;
  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;

  localparam logic [NC_W-1:0] NUM_CENTERS_RST    = NC_W'(1);
  localparam logic [FL_W-1:0] FEATURE_LENGTH_RST = FL_W'(48);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_NUM_CENTERS    = 1'b0,
    REG_FEATURE_LENGTH = 1'b1
  } cfg_reg_t;

  // Input item kinds
  typedef enum logic [0:0] {
    CMD_LOAD    = 1'b0,
    CMD_FEATURE = 1'b1
  } cmd_t;

  // Control sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

// File: rtl/l1_nearest_codeword_quantizer_unit.sv
// A load beat is written as it is accepted. A feature beat holds off the input while one
// accumulator read-modify-write runs per active center, and then through the drain state.
// On the last element the result is registered from the done state once the output is free.
// A new feature beat is taken only after the previous one has drained, and later while
// a previous result still waits on m_tready.
// Reset (rst, synchronous): accumulator valid bits clear, element count zero, registers at defaults.
// ----------------------------------------------------------------------------
// l1_nearest_codeword_quantizer_unit
// Streams feature elements against a stored codebook, accumulates the L1
// distance per center and reports the nearest center on the last element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "l1_nearest_codeword_quantizer_unit_assert.svh"

module l1_nearest_codeword_quantizer_unit #(
  parameter int MAX_CENTERS = l1ncq_pkg::MAX_CENTERS_DEF,
  parameter int MAX_DIM     = l1ncq_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [l1ncq_pkg::IN_DW-1:0] s_tdata,   // center_index, dim_index, value, 2'b0
  input  logic                        s_tuser,   // cmd
  input  logic                        s_tlast,
  // Result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [l1ncq_pkg::OUT_DW-1:0] m_tdata,  // label, distance, 2'b0
  output logic                        m_tuser,   // length_error
  // Configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [l1ncq_pkg::CFG_W-1:0] cfg_data
);

  import l1ncq_pkg::*;

  localparam int CW    = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH = MAX_CENTERS * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACT_W = $clog2(MAX_CENTERS + 1) + 1;
  localparam int SUM_W = DIST_W + 1;
  localparam int DIF_W = VAL_W + 1;

  // Input field unpacking
  logic [CI_W-1:0]  in_ci;
  logic [DI_W-1:0]  in_di;
  logic [VAL_W-1:0] in_val;
  assign in_ci  = s_tdata[CI_W-1:0];
  assign in_di  = s_tdata[CI_W+DI_W-1:CI_W];
  assign in_val = s_tdata[CI_W+DI_W+VAL_W-1:CI_W+DI_W];

  // Storage
  logic [VAL_W-1:0]  codebook [DEPTH];
  logic [DIST_W-1:0] accum    [MAX_CENTERS];
  logic [MAX_CENTERS-1:0] acc_vld;

  // Control and configuration registers
  state_t           state, state_next;
  logic [NC_W-1:0]  num_centers;
  logic [FL_W-1:0]  feature_length;
  logic [CNT_W-1:0] element_count;

  // Per-item registers
  logic [VAL_W-1:0] feat_val;
  logic             feat_last;
  logic             feat_acc;
  logic [DW-1:0]    feat_k;
  logic             feat_err;
  logic [CW-1:0]    last_c;
  logic [CW-1:0]    rd_c;

  // Second stage of the read-modify-write
  logic              p_valid;
  logic [CW-1:0]     p_c;
  logic [VAL_W-1:0]  cb_rdata;
  logic [DIST_W-1:0] acc_rdata;
  logic              acc_rvld;

  logic [DIST_W-1:0] best_dist;
  logic [CW-1:0]     best_idx;
  logic              out_free;

  logic in_fire;
  logic load_fire;
  logic feat_fire;

  assign in_fire   = s_tvalid && s_tready;
  assign load_fire = in_fire && (s_tuser == CMD_LOAD);
  assign feat_fire = in_fire && (s_tuser == CMD_FEATURE);
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  // Active center count, clamped to 1..MAX_CENTERS
  logic [ACT_W-1:0] n_act;
  always_comb begin
    priority if (num_centers == '0) begin
      n_act = ACT_W'(1);
    end else if (ACT_W'(num_centers) > ACT_W'(MAX_CENTERS)) begin
      n_act = ACT_W'(MAX_CENTERS);
    end else begin
      n_act = ACT_W'(num_centers);
    end
  end

  // Element count after this item, saturating
  logic [CNT_W-1:0] count_inc;
  assign count_inc = (element_count != COUNT_MAX) ? element_count + CNT_W'(1) : COUNT_MAX;

  // Next state and handshake
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (feat_fire) begin
          state_next = (n_act == ACT_W'(1)) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (rd_c == last_c - CW'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = feat_last ? ST_DONE : ST_IDLE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_centers    <= NUM_CENTERS_RST;
      feature_length <= FEATURE_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NUM_CENTERS:    num_centers    <= cfg_data[NC_W-1:0];
        REG_FEATURE_LENGTH: feature_length <= cfg_data[FL_W-1:0];
        default: ;
      endcase
    end
  end

  // Element count: advance per feature item, drop to zero on the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else if (feat_fire) begin
      element_count <= s_tlast ? '0 : count_inc;
    end
  end

  // Capture the feature item
  always_ff @(posedge clk) begin
    if (feat_fire) begin
      feat_val  <= in_val;
      feat_last <= s_tlast;
      feat_acc  <= (element_count < CNT_W'(MAX_DIM));
      feat_k    <= element_count[DW-1:0];
      feat_err  <= (count_inc != feature_length);
      last_c    <= CW'(n_act - ACT_W'(1));
    end
  end

  // Center read pointer: first read issued in the accept cycle
  logic          rd_en;
  logic [CW-1:0] rd_addr;
  assign rd_en   = feat_fire || (state == ST_RUN);
  assign rd_addr = (state == ST_RUN) ? rd_c + CW'(1) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_c <= '0;
    end else if (rd_en) begin
      rd_c <= rd_addr;
    end
  end

  // Codebook RAM: write on load items, read one center per cycle
  logic [AW-1:0] ld_addr;
  logic [AW-1:0] cb_raddr;
  logic [DW-1:0] rd_k;
  assign rd_k     = feat_fire ? element_count[DW-1:0] : feat_k;
  assign ld_addr  = AW'(AW'(in_ci) * AW'(MAX_DIM)) + AW'(in_di);
  assign cb_raddr = AW'(AW'(rd_addr) * AW'(MAX_DIM)) + AW'(rd_k);

  always_ff @(posedge clk) begin
    if (load_fire && (int'(in_ci) < MAX_CENTERS) && (int'(in_di) < MAX_DIM)) begin
      codebook[ld_addr] <= in_val;
    end
    if (rd_en) begin
      cb_rdata <= codebook[cb_raddr];
    end
  end

  // Accumulator RAM: read at the pointer, write back in the next cycle
  logic [DIF_W-1:0]  diff;
  logic [DIF_W-1:0]  mag;
  logic [DIST_W-1:0] acc_cur;
  logic [SUM_W-1:0]  sum;
  logic [DIST_W-1:0] acc_new;

  assign diff    = {feat_val[VAL_W-1], feat_val} - {cb_rdata[VAL_W-1], cb_rdata};
  assign mag     = diff[DIF_W-1] ? (~diff + DIF_W'(1)) : diff;
  assign acc_cur = acc_rvld ? acc_rdata : '0;
  assign sum     = {1'b0, acc_cur} + (feat_acc ? SUM_W'(mag) : '0);
  assign acc_new = sum[SUM_W-1] ? DIST_MAX : sum[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      acc_rdata <= accum[rd_addr];
      acc_rvld  <= acc_vld[rd_addr];
    end
    if (p_valid) begin
      accum[p_c] <= acc_new;
    end
  end

  // Valid bits: set on write back, clear all while in the done state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld <= '0;
    end else if (state == ST_DONE) begin
      acc_vld <= '0;
    end else if (p_valid) begin
      acc_vld[p_c] <= 1'b1;
    end
  end

  // Stage valid and center tag
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= rd_en;
    end
    if (rd_en) begin
      p_c <= rd_addr;
    end
  end

  // Track the running minimum, lowest index wins ties
  always_ff @(posedge clk) begin
    if (p_valid && ((p_c == '0) || (acc_new < best_dist))) begin
      best_dist <= acc_new;
      best_idx  <= p_c;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      m_tdata <= {{(OUT_DW - LABEL_W - DIST_W){1'b0}}, best_dist, LABEL_W'(best_idx)};
      m_tuser <= feat_err;
    end
  end

  // Checks
  `L1NCQ_ASSERT_NOW(a_idle_no_pass, s_tready, !p_valid, "input taken during a pass")
  `L1NCQ_ASSERT_NOW(a_ptr_bound, state == ST_RUN, rd_c < last_c, "center pointer ran past the last active center")
  `L1NCQ_ASSERT_NEXT(a_drain_stage, state == ST_DRAIN, !p_valid, "pipeline stage still busy after drain")
  `L1NCQ_ASSERT_NOW(a_out_source, $rose(m_tvalid), $past(state) == ST_DONE, "result raised outside hand-off")

endmodule
